[hdl/assert_macros.svh]
// Assertion macros for the top-level RTL file of the date adder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, quiet while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

[hdl/cdad_pkg.sv]
// ----------------------------------------------------------------------------
// cdad_pkg
// Types, constants and calendar helpers shared by the date adder modules.
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int YEAR_IN_W  = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int RES_W      = 9;   // year modulo 400
  localparam int CYCLE_LEN  = 400;
  localparam int YLEN_W     = 9;

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
  localparam logic [YLEN_W-1:0]  DAYS_COMMON = 9'd365;
  localparam logic [YLEN_W-1:0]  DAYS_LEAP   = 9'd366;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clamp;
    logic walk_step;
    logic year_step;
    logic month_step;
  } cdad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic year_done;
    logic month_done;
  } cdad_stat_t;

  // Year modulo 400 by six restoring compare-and-subtract steps.
  function automatic logic [RES_W-1:0] year_mod400(input logic [YEAR_IN_W-1:0] y);
    logic [YEAR_IN_W-1:0] r;
    logic [YEAR_IN_W-1:0] w;
    r = y;
    for (int k = 5; k >= 0; k--) begin
      w = YEAR_IN_W'(CYCLE_LEN) << k;
      if (r >= w) begin
        r = r - w;
      end
    end
    return r[RES_W-1:0];
  endfunction

  // Leap rule on the residue modulo 400.
  function automatic logic is_leap(input logic [RES_W-1:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

[hdl/cdad_ctrl.sv]
// ----------------------------------------------------------------------------
// cdad_ctrl
// Sequencer: load, day clamp, month-end walk, year skip, month skip, finish.
// ----------------------------------------------------------------------------
module cdad_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  output logic                out_load,
  input  cdad_pkg::cdad_stat_t stat,
  output cdad_pkg::cdad_cmd_t  cmd
);

  typedef enum logic [5:0] {
    IDLE   = 6'b000001,
    CLAMP  = 6'b000010,
    WALK   = 6'b000100,
    YEARS  = 6'b001000,
    MONTHS = 6'b010000,
    FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_load       = 1'b0;
    in_ready       = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CLAMP;
        end
      end
      CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = WALK;
      end
      WALK: begin
        if (stat.walk_done) begin
          state_next = YEARS;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      YEARS: begin
        if (stat.year_done) begin
          state_next = MONTHS;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      MONTHS: begin
        if (stat.month_done) begin
          state_next = FINISH;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

[hdl/cdad_dp.sv]
// ----------------------------------------------------------------------------
// cdad_dp
// Date registers, remaining day count and the compare/subtract unit.
// ----------------------------------------------------------------------------
module cdad_dp #(
  parameter int INCREMENT_BITS = 16
) (
  input  logic                                clk,
  input  logic [cdad_pkg::YEAR_IN_W-1:0]      start_year,
  input  logic [cdad_pkg::MONTH_W-1:0]        start_month,
  input  logic [cdad_pkg::DAY_W-1:0]          start_day,
  input  logic [INCREMENT_BITS-1:0]           day_increment,
  input  cdad_pkg::cdad_cmd_t                 cmd,
  output cdad_pkg::cdad_stat_t                stat,
  output logic [cdad_pkg::YEAR_IN_W-1:0]      end_year,
  output logic [cdad_pkg::MONTH_W-1:0]        end_month,
  output logic [cdad_pkg::DAY_W-1:0]          end_day
);

  // Years added stay below 2**(INCREMENT_BITS-8)+1, so one spare bit covers it.
  localparam int YEAR_W = ((INCREMENT_BITS - 8 > cdad_pkg::YEAR_IN_W) ?
                           INCREMENT_BITS - 8 : cdad_pkg::YEAR_IN_W) + 1;
  // The year length needs nine bits even when the count is narrower.
  localparam int CMP_W = (INCREMENT_BITS > cdad_pkg::YLEN_W) ?
                         INCREMENT_BITS : cdad_pkg::YLEN_W;

  logic [YEAR_W-1:0]                 year;
  logic [cdad_pkg::RES_W-1:0]        res;
  logic [cdad_pkg::MONTH_W-1:0]      month;
  logic [cdad_pkg::DAY_W-1:0]        day;
  logic [INCREMENT_BITS-1:0]         inc;

  logic                              leap;
  logic [cdad_pkg::DAY_W-1:0]        mlen;
  logic [cdad_pkg::DAY_W-1:0]        room;
  logic [INCREMENT_BITS-1:0]         room_ext;
  logic [INCREMENT_BITS-1:0]         mlen_ext;
  logic [CMP_W-1:0]                  inc_wide;
  logic [CMP_W-1:0]                  ylen_wide;
  logic [CMP_W-1:0]                  inc_less_year;
  logic [cdad_pkg::MONTH_W-1:0]      month_clamped;
  logic [cdad_pkg::RES_W-1:0]        res_inc;
  logic                              year_wrap;

  assign leap     = cdad_pkg::is_leap(res);
  assign mlen     = cdad_pkg::month_days(leap, month);
  assign room     = mlen - day;
  assign room_ext = INCREMENT_BITS'(room);
  assign mlen_ext = INCREMENT_BITS'(mlen);
  assign inc_wide = CMP_W'(inc);
  assign ylen_wide = CMP_W'(leap ? cdad_pkg::DAYS_LEAP : cdad_pkg::DAYS_COMMON);
  assign inc_less_year = inc_wide - ylen_wide;
  assign res_inc  = (res == cdad_pkg::RES_W'(cdad_pkg::CYCLE_LEN - 1)) ? '0 : res + 1'b1;
  assign year_wrap = (month == cdad_pkg::DECEMBER);

  always_comb begin
    if (start_month == '0) begin
      month_clamped = cdad_pkg::JANUARY;
    end else if (start_month > cdad_pkg::DECEMBER) begin
      month_clamped = cdad_pkg::DECEMBER;
    end else begin
      month_clamped = start_month;
    end
  end

  assign stat.walk_done  = (inc == '0) ||
                           (month == cdad_pkg::JANUARY && day == cdad_pkg::DAY_W'(1));
  assign stat.year_done  = (inc_wide < ylen_wide);
  assign stat.month_done = (month == cdad_pkg::DECEMBER) || (inc < mlen_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= YEAR_W'(start_year);
      res   <= cdad_pkg::year_mod400(start_year);
      month <= month_clamped;
      day   <= start_day;
      inc   <= day_increment;
    end else if (cmd.clamp) begin
      if (day == '0) begin
        day <= cdad_pkg::DAY_W'(1);
      end else if (day > mlen) begin
        day <= mlen;
      end
    end else if (cmd.walk_step) begin
      if (inc <= room_ext) begin
        day <= day + inc[cdad_pkg::DAY_W-1:0];
        inc <= '0;
      end else begin
        // Use up the rest of the month and roll into the first of the next.
        inc <= inc - room_ext - INCREMENT_BITS'(1);
        day <= cdad_pkg::DAY_W'(1);
        if (year_wrap) begin
          month <= cdad_pkg::JANUARY;
          year  <= year + 1'b1;
          res   <= res_inc;
        end else begin
          month <= month + 1'b1;
        end
      end
    end else if (cmd.year_step) begin
      inc  <= inc_less_year[INCREMENT_BITS-1:0];
      year <= year + 1'b1;
      res  <= res_inc;
    end else if (cmd.month_step) begin
      inc   <= inc - mlen_ext;
      month <= month + 1'b1;
    end
  end

  // After the month skip the remainder is below the month length.
  assign end_year  = year[cdad_pkg::YEAR_IN_W-1:0];
  assign end_month = month;
  assign end_day   = day + inc[cdad_pkg::DAY_W-1:0];

endmodule

[hdl/calendar_date_add_days_core.sv]
// Sequence: load, clamp, up to 12 month-end steps, one step per whole year skipped
// (about 180 for a 16-bit increment), up to 11 whole-month steps, then finish.
// A new item is taken only when the sequencer is back in idle; the single compare/subtract
// loop serves every step. The output register lets the next item enter while a result waits.
// Reset: synchronous, active-high rst returns the sequencer to idle and empties
// the output register.
// ----------------------------------------------------------------------------
// calendar_date_add_days_core
// Adds a day count to a Gregorian date with a sequenced year/month walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_add_days_core #(
  parameter int INCREMENT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18],
  // day_increment[22+INCREMENT_BITS:23], zero fill above
  input  logic [((23 + INCREMENT_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // end_year[13:0], end_month[17:14], end_day[22:18], zero fill [23]
  output logic [23:0]            m_axis_tdata
);

  localparam int FIELDS_W = cdad_pkg::YEAR_IN_W + cdad_pkg::MONTH_W + cdad_pkg::DAY_W;

  cdad_pkg::cdad_cmd_t  cmd;
  cdad_pkg::cdad_stat_t stat;
  logic                 out_free;
  logic                 out_load;

  logic [cdad_pkg::YEAR_IN_W-1:0] end_year;
  logic [cdad_pkg::MONTH_W-1:0]   end_month;
  logic [cdad_pkg::DAY_W-1:0]     end_day;

  logic [cdad_pkg::MONTH_W-1:0]   res_month;
  logic [cdad_pkg::DAY_W-1:0]     res_day;
  logic                           res_month_bad;
  logic                           in_take;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  cdad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .out_load (out_load),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdad_dp #(
    .INCREMENT_BITS (INCREMENT_BITS)
  ) u_dp (
    .clk           (clk),
    .start_year    (s_axis_tdata[13:0]),
    .start_month   (s_axis_tdata[17:14]),
    .start_day     (s_axis_tdata[22:18]),
    .day_increment (s_axis_tdata[FIELDS_W +: INCREMENT_BITS]),
    .cmd           (cmd),
    .stat          (stat),
    .end_year      (end_year),
    .end_month     (end_month),
    .end_day       (end_day)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, end_day, end_month, end_year};
    end
  end

  assign res_month     = m_axis_tdata[17:14];
  assign res_day       = m_axis_tdata[22:18];
  assign res_month_bad = (res_month == '0) || (res_month > cdad_pkg::DECEMBER);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  `ASSERT_NEVER(a_day_nonzero, m_axis_tvalid && (res_day == '0), "result day is zero")
  `ASSERT_NEVER(a_month_range, m_axis_tvalid && res_month_bad, "result month out of range")
  `ASSERT_CLK(a_busy_after_accept, in_take |=> !s_axis_tready, "input taken while busy")
  `ASSERT_CLK(a_idle_after_load, out_load |=> s_axis_tready && m_axis_tvalid, "no idle after load")

endmodule

[test/calendar_date_add_days_core_tb.sv]
// ----------------------------------------------------------------------------
// calendar_date_add_days_core_tb
// Self-checking bench for the date adder. Items of start date and day count
// go in on the slave stream. A scoreboard computes the expected end date for
// each accepted item and compares it with the results on the master stream.
// Both sides idle at random. The receiver holds off once for a long stretch
// so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module calendar_date_add_days_core_tb;

  localparam int INC_W = 16;
  localparam int IN_W  = ((23 + INC_W + 7) / 8) * 8;
  localparam int N_RANDOM = 650;
  localparam int HOLD_AT = 150;     // result count at which the long hold starts
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_date_t;

  class date_scoreboard;
    cal_date_t expected_q[$];
    int errors;
    int checked;
    int noted;

    static function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int unsigned month_len(int unsigned y, int unsigned m);
      case (m)
        2:             return leap_year(y) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    static function int unsigned year_len(int unsigned y);
      return leap_year(y) ? 366 : 365;
    endfunction

    // End date of a start date plus a day count, with the block's clamping.
    static function cal_date_t calc_end_date(logic [13:0] sy, logic [3:0] sm,
                                             logic [4:0] sd, logic [INC_W-1:0] count);
      int unsigned y, m, d, left, room, take;
      cal_date_t r;
      y = sy;
      m = sm;
      d = sd;
      left = count;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (d < 1) d = 1;
      if (d > month_len(y, m)) d = month_len(y, m);
      // Roll over month ends until the count runs out or the date is January 1.
      while (left > 0 && !(m == 1 && d == 1)) begin
        room = month_len(y, m) - d;
        take = (left < room) ? left : room;
        d += take;
        left -= take;
        if (left > 0) begin
          left--;
          m++;
          d = 1;
          if (m > 12) begin
            m = 1;
            y++;
          end
        end
      end
      if (left > 0) begin
        while (left >= year_len(y)) begin
          left -= year_len(y);
          y++;
        end
        while (m < 12 && left >= month_len(y, m)) begin
          left -= month_len(y, m);
          m++;
        end
        d += left;
      end
      r.year  = 14'(y);
      r.month = 4'(m);
      r.day   = 5'(d);
      return r;
    endfunction

    function void note_item(logic [IN_W-1:0] data);
      expected_q.push_back(calc_end_date(data[13:0], data[17:14], data[22:18],
                                         data[22+INC_W:23]));
      noted++;
    endfunction

    function void check_result(logic [23:0] data);
      cal_date_t want;
      if (expected_q.size() == 0) begin
        $error("result %h arrived with no item outstanding", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (data[13:0] !== want.year) begin
        $error("end_year: expected %0d, got %0d", want.year, data[13:0]);
        errors++;
      end
      if (data[17:14] !== want.month) begin
        $error("end_month: expected %0d, got %0d", want.month, data[17:14]);
        errors++;
      end
      if (data[22:18] !== want.day) begin
        $error("end_day: expected %0d, got %0d", want.day, data[22:18]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [23:0]     m_axis_tdata;

  date_scoreboard sb = new();
  int long_counts;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calendar_date_add_days_core #(
    .INCREMENT_BITS(INC_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic logic [IN_W-1:0] pack_item(logic [13:0] y, logic [3:0] m,
                                                logic [4:0] d, logic [INC_W-1:0] n);
    logic [IN_W-1:0] data;
    data = '0;
    data[13:0] = y;
    data[17:14] = m;
    data[22:18] = d;
    data[22+INC_W:23] = n;
    return data;
  endfunction

  // Random idle length: mostly zero or short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 11) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Offers one item and returns once it has been accepted. The task lowers
  // tvalid only when a gap is asked for, so tvalid is never dropped and raised in one step.
  task automatic send_item(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                           logic [INC_W-1:0] n, int gap);
    logic [IN_W-1:0] data;
    data = pack_item(y, m, d, n);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= data;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(data);
    if (n >= 4000) long_counts++;
  endtask

  task automatic send_random(int gap);
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [INC_W-1:0] n;
    int unsigned pick;
    y = ($urandom_range(0, 6) == 0) ? 14'($urandom_range(0, 16383))
                                    : 14'($urandom_range(0, 9999));
    m = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                    : 4'($urandom_range(1, 12));
    if ($urandom_range(0, 7) == 0) begin
      d = 5'($urandom_range(0, 31));
    end else if (m >= 1 && m <= 12) begin
      d = 5'($urandom_range(1, date_scoreboard::month_len(y, m)));
    end else begin
      d = 5'($urandom_range(1, 31));
    end
    // A start on January 1 goes straight to the whole-year skip.
    if ($urandom_range(0, 9) == 0) begin
      m = 4'd1;
      d = 5'd1;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5)      n = INC_W'($urandom_range(0, 400));
    else if (pick < 8) n = INC_W'($urandom_range(0, 4000));
    else               n = INC_W'($urandom_range(0, (1 << INC_W) - 1));
    send_item(y, m, d, n, gap);
  endtask

  // Receiver: random stalls, stretches without any, and one long hold.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && sb.checked >= HOLD_AT) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end else if ((sb.checked % 120) < 35) begin
        stall = 0;
      end else begin
        stall = idle_len();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    #10_000_000;
    $display("calendar_date_add_days_core_tb: done, errors");
    $finish;
  end

  initial begin
    int gap;
    long_counts = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: clamping, zero count, leap rules, year rollover, field extremes.
    send_item(14'd2024, 4'd2, 5'd29, 16'd0, 0);
    send_item(14'd2023, 4'd0, 5'd0, 16'd0, 0);
    send_item(14'd2023, 4'd15, 5'd31, 16'd0, 0);
    send_item(14'd2023, 4'd13, 5'd15, 16'd20, 1);
    send_item(14'd2023, 4'd2, 5'd31, 16'd1, 0);
    send_item(14'd2024, 4'd2, 5'd31, 16'd1, 0);
    send_item(14'd2021, 4'd4, 5'd31, 16'd5, 2);
    send_item(14'd1999, 4'd12, 5'd31, 16'd1, 0);
    send_item(14'd2000, 4'd2, 5'd28, 16'd1, 0);
    send_item(14'd1900, 4'd2, 5'd28, 16'd1, 0);
    send_item(14'd2100, 4'd2, 5'd28, 16'd1, 0);
    send_item(14'd2023, 4'd1, 5'd1, 16'd364, 0);
    send_item(14'd2023, 4'd1, 5'd1, 16'd365, 3);
    send_item(14'd2024, 4'd1, 5'd1, 16'd365, 0);
    send_item(14'd2024, 4'd1, 5'd1, 16'd366, 0);
    send_item(14'd2024, 4'd1, 5'd31, 16'd29, 0);
    send_item(14'd2023, 4'd12, 5'd1, 16'd30, 0);
    send_item(14'd0, 4'd1, 5'd1, 16'd65535, 0);
    send_item(14'd9999, 4'd12, 5'd31, 16'd65535, 5);
    send_item(14'd16383, 4'd15, 5'd31, 16'd65535, 0);
    send_item(14'd16383, 4'd1, 5'd1, 16'd0, 0);
    send_item(14'd9999, 4'd12, 5'd31, 16'd0, 0);
    send_item(14'd2023, 4'd3, 5'd15, 16'd40000, 0);
    send_item(14'd1, 4'd11, 5'd30, 16'd32768, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      gap = ((i % 100) < 25) ? 0 : idle_len();
      send_random(gap);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, %0d with a count of 4000 days or more; checked %0d results.",
             sb.noted, long_counts, sb.checked);
    $display("Covered field clamping, leap and century years, long holds and idle gaps.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("calendar_date_add_days_core_tb: done, clean");
    end else begin
      $display("calendar_date_add_days_core_tb: done, errors");
    end
    $finish;
  end

endmodule
